[sv/tftdc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tftdc_pkg: shared constants of the TFT draw command sequencer
// Operation codes, display controller commands, sequencer phase codes and the
// font store geometry.
// ----------------------------------------------------------------------------
package tftdc_pkg;

    // Input operations.
    localparam logic [1:0] OP_FILL  = 2'd0;
    localparam logic [1:0] OP_GLYPH = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    // Display controller commands.
    localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
    localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
    localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

    // Sequencer phases: idle, the eleven header words, then pixels.
    localparam logic [3:0] PHASE_IDLE    = 4'd0;
    localparam logic [3:0] PHASE_COL_CMD = 4'd1;
    localparam logic [3:0] PHASE_XS_HI   = 4'd2;
    localparam logic [3:0] PHASE_XS_LO   = 4'd3;
    localparam logic [3:0] PHASE_XE_HI   = 4'd4;
    localparam logic [3:0] PHASE_XE_LO   = 4'd5;
    localparam logic [3:0] PHASE_ROW_CMD = 4'd6;
    localparam logic [3:0] PHASE_YS_HI   = 4'd7;
    localparam logic [3:0] PHASE_YS_LO   = 4'd8;
    localparam logic [3:0] PHASE_YE_HI   = 4'd9;
    localparam logic [3:0] PHASE_YE_LO   = 4'd10;
    localparam logic [3:0] PHASE_MEM_CMD = 4'd11;
    localparam logic [3:0] PHASE_PIXELS  = 4'd12;

    // Configuration register indexes.
    localparam logic REG_FOREGROUND = 1'b0;
    localparam logic REG_BACKGROUND = 1'b1;

    localparam logic [15:0] FOREGROUND_RESET = 16'hFFFF;
    localparam logic [15:0] BACKGROUND_RESET = 16'h0000;

    // Font geometry: eight rows per glyph, each row drawn on two lines.
    localparam int FONT_ROWS           = 8;
    localparam int FONT_GLYPHS_DEFAULT = 128;
    localparam int GLYPH_CODE_W        = 7;
    localparam int ROW_INDEX_W         = 3;

    // Window size of a glyph, as end offsets from the corner.
    localparam logic [15:0] GLYPH_X_SPAN = 16'd7;
    localparam logic [15:0] GLYPH_Y_SPAN = 16'd15;
    localparam logic [6:0]  GLYPH_LAST_PIXEL = 7'd127;

endpackage : tftdc_pkg
`default_nettype wire

[sv/tft_draw_command_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tft_draw_command_sequencer
// Turns fill and glyph requests into the command, window and pixel word
// stream of an SPI display controller, one word per tick item during a drawing.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Carries
//  s_*       in         s_valid / s_ready      operation and its operands
//  m_*       out        m_valid / m_ready      one word with its framing flags
//  APB       in         psel/penable, pready   foreground, background colour
//
//  One item is taken per cycle, except that a tick which yields a word waits
//  for room in the output register. An item is held in the input register,
//  where short logic updates the sequencer state; a word it causes is written
//  to the output register as the item leaves the input register. The font
//  store read is registered and addressed from the next state, with a write
//  bypass, so a row change does not stall the pixel words. aresetn is
//  synchronous and clears the control state; the font store is not cleared.
// ----------------------------------------------------------------------------
module tft_draw_command_sequencer #(
    parameter int FONT_GLYPHS = tftdc_pkg::FONT_GLYPHS_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_operation,
    input  wire logic [15:0] s_pos_x,
    input  wire logic [15:0] s_pos_y,
    input  wire logic [15:0] s_rect_width,
    input  wire logic [15:0] s_rect_height,
    input  wire logic [15:0] s_fill_colour,
    input  wire logic [6:0]  s_glyph_code,
    input  wire logic [2:0]  s_font_row_index,
    input  wire logic [7:0]  s_font_row_bits,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_out_word,
    output logic             m_is_data,
    output logic             m_wide_frame,
    output logic             m_last_word,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int FONT_DEPTH = FONT_GLYPHS * tftdc_pkg::FONT_ROWS;
    localparam int ADDR_W     = $clog2(FONT_DEPTH);

    // Configuration registers.
    logic [15:0] foreground_reg;
    logic [15:0] background_reg;
    logic        cfg_write;

    // Input register.
    logic        s1_valid_reg;
    logic [1:0]  s1_op_reg;
    logic [15:0] s1_x_reg;
    logic [15:0] s1_y_reg;
    logic [15:0] s1_w_reg;
    logic [15:0] s1_h_reg;
    logic [15:0] s1_colour_reg;
    logic [6:0]  s1_glyph_reg;
    logic [2:0]  s1_row_reg;
    logic [7:0]  s1_bits_reg;

    // Sequencer state.
    logic [3:0]  phase_reg,         phase_next;
    logic        drawing_glyph_reg, drawing_glyph_next;
    logic [15:0] win_x_start_reg,   win_x_start_next;
    logic [15:0] win_x_end_reg,     win_x_end_next;
    logic [15:0] win_y_start_reg,   win_y_start_next;
    logic [15:0] win_y_end_reg,     win_y_end_next;
    logic [15:0] held_colour_reg,   held_colour_next;
    logic [31:0] pixels_left_reg,   pixels_left_next;
    logic [6:0]  held_glyph_reg,    held_glyph_next;
    logic [6:0]  glyph_pixel_reg,   glyph_pixel_next;

    // Font store.
    logic [7:0]        font_mem [FONT_DEPTH];
    logic [7:0]        font_rd_reg;
    logic [ADDR_W-1:0] font_rd_addr;
    logic [ADDR_W-1:0] font_wr_addr;
    logic              font_we;
    logic              glyph_in_store;
    logic              pixel_bit;

    // Output register.
    logic        m_valid_reg;
    logic [15:0] m_word_reg;
    logic        m_data_reg;
    logic        m_wide_reg;
    logic        m_last_reg;

    // Per-item combinational result.
    logic        s1_fire;
    logic        s1_yields;
    logic        out_free;
    logic        res_valid;
    logic [15:0] res_word;
    logic        res_data;
    logic        res_wide;
    logic        res_last;
    logic [31:0] fill_pixels;

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            foreground_reg <= tftdc_pkg::FOREGROUND_RESET;
            background_reg <= tftdc_pkg::BACKGROUND_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == tftdc_pkg::REG_FOREGROUND) begin
                foreground_reg <= pwdata[15:0];
            end else begin
                background_reg <= pwdata[15:0];
            end
        end
    end

    assign prdata = (paddr[2] == tftdc_pkg::REG_FOREGROUND) ? {16'd0, foreground_reg}
                                                            : {16'd0, background_reg};

    // ------------------------------------------------------------------
    // Handshake. Only a tick during a drawing yields a word, and only such
    // an item waits for room in the output register.
    // ------------------------------------------------------------------
    assign out_free  = !m_valid_reg || m_ready;
    assign s1_yields = (s1_op_reg == tftdc_pkg::OP_TICK) &&
                       (phase_reg inside {[tftdc_pkg::PHASE_COL_CMD:tftdc_pkg::PHASE_PIXELS]});
    assign s1_fire   = s1_valid_reg && (!s1_yields || out_free);
    assign s_ready   = !s1_valid_reg || s1_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_op_reg     <= s_operation;
            s1_x_reg      <= s_pos_x;
            s1_y_reg      <= s_pos_y;
            s1_w_reg      <= s_rect_width;
            s1_h_reg      <= s_rect_height;
            s1_colour_reg <= s_fill_colour;
            s1_glyph_reg  <= s_glyph_code;
            s1_row_reg    <= s_font_row_index;
            s1_bits_reg   <= s_font_row_bits;
        end
    end

    // ------------------------------------------------------------------
    // Font store. The read address follows the next state, so the row
    // register always holds the row of the current glyph pixel. A load in
    // the same cycle to that row is forwarded.
    // ------------------------------------------------------------------
    assign glyph_in_store = (int'(held_glyph_reg) < FONT_GLYPHS);
    assign font_we        = s1_fire && (s1_op_reg == tftdc_pkg::OP_LOAD) &&
                            (int'(s1_glyph_reg) < FONT_GLYPHS);
    assign font_wr_addr   = ADDR_W'({s1_glyph_reg, s1_row_reg});
    assign font_rd_addr   = ADDR_W'({held_glyph_next, glyph_pixel_next[6:4]});

    always_ff @(posedge aclk) begin
        if (font_we) begin
            font_mem[font_wr_addr] <= s1_bits_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (font_we && (font_wr_addr == font_rd_addr)) begin
            font_rd_reg <= s1_bits_reg;
        end else begin
            font_rd_reg <= font_mem[font_rd_addr];
        end
    end

    assign pixel_bit = glyph_in_store && font_rd_reg[glyph_pixel_reg[2:0]];

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    assign fill_pixels = s1_w_reg * s1_h_reg;

    always_comb begin
        phase_next         = phase_reg;
        drawing_glyph_next = drawing_glyph_reg;
        win_x_start_next   = win_x_start_reg;
        win_x_end_next     = win_x_end_reg;
        win_y_start_next   = win_y_start_reg;
        win_y_end_next     = win_y_end_reg;
        held_colour_next   = held_colour_reg;
        pixels_left_next   = pixels_left_reg;
        held_glyph_next    = held_glyph_reg;
        glyph_pixel_next   = glyph_pixel_reg;
        res_valid          = 1'b0;
        res_word           = 16'd0;
        res_data           = 1'b1;
        res_wide           = 1'b0;
        res_last           = 1'b0;

        if (s1_fire) begin
            case (s1_op_reg)
                tftdc_pkg::OP_FILL, tftdc_pkg::OP_GLYPH: begin
                    // A start request during a drawing is dropped.
                    if (phase_reg == tftdc_pkg::PHASE_IDLE) begin
                        win_x_start_next = s1_x_reg;
                        win_y_start_next = s1_y_reg;
                        phase_next       = tftdc_pkg::PHASE_COL_CMD;
                        if (s1_op_reg == tftdc_pkg::OP_FILL) begin
                            win_x_end_next     = s1_x_reg + s1_w_reg - 16'd1;
                            win_y_end_next     = s1_y_reg + s1_h_reg - 16'd1;
                            held_colour_next   = s1_colour_reg;
                            pixels_left_next   = fill_pixels;
                            drawing_glyph_next = 1'b0;
                        end else begin
                            win_x_end_next     = s1_x_reg + tftdc_pkg::GLYPH_X_SPAN;
                            win_y_end_next     = s1_y_reg + tftdc_pkg::GLYPH_Y_SPAN;
                            held_glyph_next    = s1_glyph_reg;
                            glyph_pixel_next   = 7'd0;
                            drawing_glyph_next = 1'b1;
                        end
                    end
                end
                tftdc_pkg::OP_TICK: begin
                    case (phase_reg)
                        tftdc_pkg::PHASE_COL_CMD: begin
                            res_valid = 1'b1;
                            res_word  = {8'd0, tftdc_pkg::CMD_COLUMN_SET};
                            res_data  = 1'b0;
                        end
                        tftdc_pkg::PHASE_XS_HI: begin
                            res_valid = 1'b1;
                            res_word  = {8'd0, win_x_start_reg[15:8]};
                        end
                        tftdc_pkg::PHASE_XS_LO: begin
                            res_valid = 1'b1;
                            res_word  = {8'd0, win_x_start_reg[7:0]};
                        end
                        tftdc_pkg::PHASE_XE_HI: begin
                            res_valid = 1'b1;
                            res_word  = {8'd0, win_x_end_reg[15:8]};
                        end
                        tftdc_pkg::PHASE_XE_LO: begin
                            res_valid = 1'b1;
                            res_word  = {8'd0, win_x_end_reg[7:0]};
                        end
                        tftdc_pkg::PHASE_ROW_CMD: begin
                            res_valid = 1'b1;
                            res_word  = {8'd0, tftdc_pkg::CMD_ROW_SET};
                            res_data  = 1'b0;
                        end
                        tftdc_pkg::PHASE_YS_HI: begin
                            res_valid = 1'b1;
                            res_word  = {8'd0, win_y_start_reg[15:8]};
                        end
                        tftdc_pkg::PHASE_YS_LO: begin
                            res_valid = 1'b1;
                            res_word  = {8'd0, win_y_start_reg[7:0]};
                        end
                        tftdc_pkg::PHASE_YE_HI: begin
                            res_valid = 1'b1;
                            res_word  = {8'd0, win_y_end_reg[15:8]};
                        end
                        tftdc_pkg::PHASE_YE_LO: begin
                            res_valid = 1'b1;
                            res_word  = {8'd0, win_y_end_reg[7:0]};
                        end
                        tftdc_pkg::PHASE_MEM_CMD: begin
                            res_valid = 1'b1;
                            res_word  = {8'd0, tftdc_pkg::CMD_MEMORY_WRITE};
                            res_data  = 1'b0;
                            // An empty fill ends with the memory-write command.
                            if (!drawing_glyph_reg && (pixels_left_reg == 32'd0)) begin
                                res_last   = 1'b1;
                                phase_next = tftdc_pkg::PHASE_IDLE;
                            end else begin
                                phase_next = tftdc_pkg::PHASE_PIXELS;
                            end
                        end
                        tftdc_pkg::PHASE_PIXELS: begin
                            res_valid = 1'b1;
                            res_wide  = 1'b1;
                            if (drawing_glyph_reg) begin
                                res_word = pixel_bit ? foreground_reg : background_reg;
                                res_last = (glyph_pixel_reg == tftdc_pkg::GLYPH_LAST_PIXEL);
                                if (res_last) begin
                                    phase_next       = tftdc_pkg::PHASE_IDLE;
                                    glyph_pixel_next = 7'd0;
                                end else begin
                                    glyph_pixel_next = glyph_pixel_reg + 7'd1;
                                end
                            end else begin
                                res_word = held_colour_reg;
                                res_last = (pixels_left_reg <= 32'd1);
                                if (res_last) begin
                                    pixels_left_next = 32'd0;
                                    phase_next       = tftdc_pkg::PHASE_IDLE;
                                end else begin
                                    pixels_left_next = pixels_left_reg - 32'd1;
                                end
                            end
                        end
                        default: begin
                            res_valid = 1'b0;
                        end
                    endcase
                    // Header words advance one phase at a time.
                    if (phase_reg inside {[tftdc_pkg::PHASE_COL_CMD:tftdc_pkg::PHASE_YE_LO]}) begin
                        phase_next = phase_reg + 4'd1;
                    end
                end
                default: begin
                    // A font load only touches the store.
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= tftdc_pkg::PHASE_IDLE;
            drawing_glyph_reg <= 1'b0;
            pixels_left_reg   <= 32'd0;
            held_glyph_reg    <= 7'd0;
            glyph_pixel_reg   <= 7'd0;
            win_x_start_reg   <= 16'd0;
            win_x_end_reg     <= 16'd0;
            win_y_start_reg   <= 16'd0;
            win_y_end_reg     <= 16'd0;
            held_colour_reg   <= 16'd0;
        end else begin
            phase_reg         <= phase_next;
            drawing_glyph_reg <= drawing_glyph_next;
            pixels_left_reg   <= pixels_left_next;
            held_glyph_reg    <= held_glyph_next;
            glyph_pixel_reg   <= glyph_pixel_next;
            win_x_start_reg   <= win_x_start_next;
            win_x_end_reg     <= win_x_end_next;
            win_y_start_reg   <= win_y_start_next;
            win_y_end_reg     <= win_y_end_next;
            held_colour_reg   <= held_colour_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_word_reg <= res_word;
            m_data_reg <= res_data;
            m_wide_reg <= res_wide;
            m_last_reg <= res_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_word   = m_word_reg;
    assign m_is_data    = m_data_reg;
    assign m_wide_frame = m_wide_reg;
    assign m_last_word  = m_last_reg;

endmodule : tft_draw_command_sequencer
`default_nettype wire

[test/tft_draw_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tft_draw_checker
// Watches the request, word and register ports of the draw command sequencer.
// It keeps its own copy of the sequencer state, the font store and the two
// colour registers, works out the word that each accepted tick should give,
// and compares every word that leaves the block against the oldest one
// still outstanding.
// ----------------------------------------------------------------------------
module tft_draw_checker
    import tftdc_pkg::*;
#(
    parameter int FONT_GLYPHS = FONT_GLYPHS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [15:0] s_pos_x,
    input  logic [15:0] s_pos_y,
    input  logic [15:0] s_rect_width,
    input  logic [15:0] s_rect_height,
    input  logic [15:0] s_fill_colour,
    input  logic [6:0]  s_glyph_code,
    input  logic [2:0]  s_font_row_index,
    input  logic [7:0]  s_font_row_bits,

    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_out_word,
    input  logic        m_is_data,
    input  logic        m_wide_frame,
    input  logic        m_last_word,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,

    output int          fail_count,
    output int          pending,
    output logic        drawing
);

    typedef struct packed {
        logic [15:0] word;
        logic        is_data;
        logic        wide;
        logic        last;
    } lcd_word_t;

    lcd_word_t   expected_words[$];
    lcd_word_t   want;

    logic [15:0] fg_colour;
    logic [15:0] bg_colour;

    logic [3:0]  seq_phase;
    logic        glyph_mode;
    logic [15:0] win_x0, win_x1, win_y0, win_y1;
    logic [15:0] fill_rgb;
    logic [31:0] pixels_remaining;
    logic [6:0]  glyph_sel;
    logic [6:0]  glyph_pos;
    logic [7:0]  font_rows [FONT_GLYPHS * FONT_ROWS];

    logic [7:0]  row_bits;
    logic        is_last;

    initial begin
        fail_count = 0;
        pending    = 0;
        drawing    = 1'b0;
    end

    function logic [15:0] header_byte(input logic [3:0] ph);
        case (ph)
            PHASE_COL_CMD: return {8'h00, CMD_COLUMN_SET};
            PHASE_XS_HI:   return {8'h00, win_x0[15:8]};
            PHASE_XS_LO:   return {8'h00, win_x0[7:0]};
            PHASE_XE_HI:   return {8'h00, win_x1[15:8]};
            PHASE_XE_LO:   return {8'h00, win_x1[7:0]};
            PHASE_ROW_CMD: return {8'h00, CMD_ROW_SET};
            PHASE_YS_HI:   return {8'h00, win_y0[15:8]};
            PHASE_YS_LO:   return {8'h00, win_y0[7:0]};
            PHASE_YE_HI:   return {8'h00, win_y1[15:8]};
            PHASE_YE_LO:   return {8'h00, win_y1[7:0]};
            default:       return {8'h00, CMD_MEMORY_WRITE};
        endcase
    endfunction

    task automatic expect_word(input logic [15:0] w, input logic d, input logic wd,
                               input logic l);
        lcd_word_t e;
        e.word    = w;
        e.is_data = d;
        e.wide    = wd;
        e.last    = l;
        expected_words.push_back(e);
    endtask

    // One accepted request moves the sequencer on by one step.
    task advance_sequencer();
        case (s_operation)
            OP_FILL, OP_GLYPH: begin
                // A new window is only taken while nothing is being drawn.
                if (seq_phase == PHASE_IDLE) begin
                    win_x0 = s_pos_x;
                    win_y0 = s_pos_y;
                    if (s_operation == OP_FILL) begin
                        win_x1           = s_pos_x + s_rect_width - 16'd1;
                        win_y1           = s_pos_y + s_rect_height - 16'd1;
                        fill_rgb         = s_fill_colour;
                        pixels_remaining = {16'h0000, s_rect_width}
                                           * {16'h0000, s_rect_height};
                        glyph_mode       = 1'b0;
                    end else begin
                        win_x1     = s_pos_x + GLYPH_X_SPAN;
                        win_y1     = s_pos_y + GLYPH_Y_SPAN;
                        glyph_sel  = s_glyph_code;
                        glyph_pos  = '0;
                        glyph_mode = 1'b1;
                    end
                    seq_phase = PHASE_COL_CMD;
                end
            end
            OP_LOAD: begin
                if (int'(s_glyph_code) < FONT_GLYPHS)
                    font_rows[int'(s_glyph_code) * FONT_ROWS + int'(s_font_row_index)] =
                        s_font_row_bits;
            end
            default: begin
                if (seq_phase == PHASE_IDLE) begin
                    // A tick with nothing to draw gives no word.
                end else if (seq_phase < PHASE_PIXELS) begin
                    is_last = 1'b0;
                    expect_word(header_byte(seq_phase),
                                !(seq_phase == PHASE_COL_CMD || seq_phase == PHASE_ROW_CMD
                                  || seq_phase == PHASE_MEM_CMD),
                                1'b0,
                                seq_phase == PHASE_MEM_CMD && !glyph_mode
                                    && pixels_remaining == 0);
                    if (seq_phase == PHASE_MEM_CMD) begin
                        if (!glyph_mode && pixels_remaining == 0)
                            seq_phase = PHASE_IDLE;
                        else
                            seq_phase = PHASE_PIXELS;
                    end else begin
                        seq_phase = seq_phase + 4'd1;
                    end
                end else if (glyph_mode) begin
                    // Each font row covers two 8-pixel lines, bit 0 leftmost.
                    if (int'(glyph_sel) < FONT_GLYPHS)
                        row_bits = font_rows[int'(glyph_sel) * FONT_ROWS
                                             + int'(glyph_pos[6:4])];
                    else
                        row_bits = '0;
                    is_last = (glyph_pos == GLYPH_LAST_PIXEL);
                    expect_word(row_bits[glyph_pos[2:0]] ? fg_colour : bg_colour,
                                1'b1, 1'b1, is_last);
                    if (is_last) begin
                        seq_phase = PHASE_IDLE;
                        glyph_pos = '0;
                    end else begin
                        glyph_pos = glyph_pos + 7'd1;
                    end
                end else begin
                    is_last = (pixels_remaining <= 1);
                    expect_word(fill_rgb, 1'b1, 1'b1, is_last);
                    if (pixels_remaining != 0)
                        pixels_remaining = pixels_remaining - 1;
                    if (is_last) begin
                        pixels_remaining = '0;
                        seq_phase        = PHASE_IDLE;
                    end
                end
            end
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            fg_colour        = FOREGROUND_RESET;
            bg_colour        = BACKGROUND_RESET;
            seq_phase        = PHASE_IDLE;
            glyph_mode       = 1'b0;
            win_x0           = '0;
            win_x1           = '0;
            win_y0           = '0;
            win_y1           = '0;
            fill_rgb         = '0;
            pixels_remaining = '0;
            glyph_sel        = '0;
            glyph_pos        = '0;
            expected_words.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word: word %h data %b wide %b last %b",
                             $time, m_out_word, m_is_data, m_wide_frame, m_last_word);
                    fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_out_word !== want.word || m_is_data !== want.is_data
                            || m_wide_frame !== want.wide || m_last_word !== want.last) begin
                        $display("%0t: word mismatch: expected word %h data %b wide %b last %b,",
                                 $time, want.word, want.is_data, want.wide, want.last);
                        $display("%0t:   actual word %h data %b wide %b last %b",
                                 $time, m_out_word, m_is_data, m_wide_frame, m_last_word);
                        fail_count++;
                    end
                end
            end

            if (s_valid && s_ready)
                advance_sequencer();

            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[2] == REG_FOREGROUND)
                        fg_colour = pwdata[15:0];
                    else
                        bg_colour = pwdata[15:0];
                end else begin
                    want.word = (paddr[2] == REG_FOREGROUND) ? fg_colour : bg_colour;
                    if (prdata !== {16'h0000, want.word}) begin
                        $display("%0t: register read at %h: expected %h, actual %h",
                                 $time, paddr, {16'h0000, want.word}, prdata);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_words.size();
        drawing = (seq_phase != PHASE_IDLE);
    end

endmodule

[test/tft_draw_command_sequencer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tft_draw_command_sequencer_tb
// Drives fill, glyph, font load and tick requests into the sequencer, first a
// short directed run over window wrap, empty fills, ignored starts and font
// loads during a glyph, then random drawings under four idle and stall
// patterns with colour register changes in between. Checking is done by
// tft_draw_checker, which sits beside the block.
// ----------------------------------------------------------------------------
module tft_draw_command_sequencer_tb;
    import tftdc_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int PHASE_ITEMS  = 45;
    localparam int GLYPH_WORDS  = 11 + 128;
    localparam int HEADER_WORDS = 11;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
        logic [15:0] colour;
        logic [6:0]  glyph;
        logic [2:0]  row;
        logic [7:0]  bits;
    } draw_req_t;

    logic        aclk = 1'b0;
    logic        aresetn;

    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_operation;
    logic [15:0] s_pos_x;
    logic [15:0] s_pos_y;
    logic [15:0] s_rect_width;
    logic [15:0] s_rect_height;
    logic [15:0] s_fill_colour;
    logic [6:0]  s_glyph_code;
    logic [2:0]  s_font_row_index;
    logic [7:0]  s_font_row_bits;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_out_word;
    logic        m_is_data;
    logic        m_wide_frame;
    logic        m_last_word;

    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    logic        drawing;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          requests_sent  = 0;
    int          quiet_cycles   = 0;

    // Rows written so far per glyph; only fully written glyphs are drawn.
    logic [7:0]  rows_loaded [2**GLYPH_CODE_W];
    int          drawable_glyphs[$];

    tft_draw_command_sequencer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_pos_x          (s_pos_x),
        .s_pos_y          (s_pos_y),
        .s_rect_width     (s_rect_width),
        .s_rect_height    (s_rect_height),
        .s_fill_colour    (s_fill_colour),
        .s_glyph_code     (s_glyph_code),
        .s_font_row_index (s_font_row_index),
        .s_font_row_bits  (s_font_row_bits),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_word       (m_out_word),
        .m_is_data        (m_is_data),
        .m_wide_frame     (m_wide_frame),
        .m_last_word      (m_last_word),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    tft_draw_checker word_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_pos_x          (s_pos_x),
        .s_pos_y          (s_pos_y),
        .s_rect_width     (s_rect_width),
        .s_rect_height    (s_rect_height),
        .s_fill_colour    (s_fill_colour),
        .s_glyph_code     (s_glyph_code),
        .s_font_row_index (s_font_row_index),
        .s_font_row_bits  (s_font_row_bits),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_word       (m_out_word),
        .m_is_data        (m_is_data),
        .m_wide_frame     (m_wide_frame),
        .m_last_word      (m_last_word),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .fail_count       (fail_count),
        .pending          (pending),
        .drawing          (drawing)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic draw_req_t random_request();
        draw_req_t r;
        r.op     = 2'($urandom_range(3));
        r.x      = 16'($urandom);
        r.y      = 16'($urandom);
        r.w      = 16'($urandom);
        r.h      = 16'($urandom);
        r.colour = 16'($urandom);
        r.glyph  = 7'($urandom);
        r.row    = 3'($urandom);
        r.bits   = 8'($urandom);
        return r;
    endfunction

    // Mostly tiny rectangles; full-range sizes only with an empty other side.
    function automatic draw_req_t sized_fill(input draw_req_t r);
        int unsigned pick;
        pick = $urandom_range(19);
        r.op = OP_FILL;
        if (pick == 0) begin
            r.h = '0;
        end else if (pick == 1) begin
            r.w = '0;
        end else if (pick == 2) begin
            r.w = 16'($urandom_range(300));
            r.h = 16'd1;
        end else begin
            r.w = 16'($urandom_range(6));
            r.h = 16'($urandom_range(6));
        end
        return r;
    endfunction

    function automatic logic [6:0] pick_glyph();
        return 7'(drawable_glyphs[$urandom_range(drawable_glyphs.size() - 1)]);
    endfunction

    // Called just after a falling edge; returns just after the falling edge
    // that follows acceptance.
    task automatic drive_request(input draw_req_t r);
        logic was_full;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        if (r.op != OP_TICK || drawing)
            requests_sent++;
        if (r.op == OP_LOAD) begin
            was_full = &rows_loaded[r.glyph];
            rows_loaded[r.glyph][r.row] = 1'b1;
            if (!was_full && &rows_loaded[r.glyph])
                drawable_glyphs.push_back(int'(r.glyph));
        end
        s_valid          = 1'b1;
        s_operation      = r.op;
        s_pos_x          = r.x;
        s_pos_y          = r.y;
        s_rect_width     = r.w;
        s_rect_height    = r.h;
        s_fill_colour    = r.colour;
        s_glyph_code     = r.glyph;
        s_font_row_index = r.row;
        s_font_row_bits  = r.bits;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_ticks(input int n);
        draw_req_t r;
        repeat (n) begin
            r    = random_request();
            r.op = OP_TICK;
            drive_request(r);
        end
    endtask

    task automatic send_fill(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] w, input logic [15:0] h,
                             input logic [15:0] colour);
        draw_req_t r;
        r        = random_request();
        r.op     = OP_FILL;
        r.x      = x;
        r.y      = y;
        r.w      = w;
        r.h      = h;
        r.colour = colour;
        drive_request(r);
    endtask

    task automatic send_glyph(input logic [15:0] x, input logic [15:0] y,
                              input logic [6:0] code);
        draw_req_t r;
        r       = random_request();
        r.op    = OP_GLYPH;
        r.x     = x;
        r.y     = y;
        r.glyph = code;
        drive_request(r);
    endtask

    task automatic send_load(input logic [6:0] code, input logic [2:0] row,
                             input logic [7:0] bits);
        draw_req_t r;
        r       = random_request();
        r.op    = OP_LOAD;
        r.glyph = code;
        r.row   = row;
        r.bits  = bits;
        drive_request(r);
    endtask

    task automatic hold_until_drained();
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    // Finish any drawing left open and let every word out before registers are touched.
    task automatic quiesce();
        while (drawing) send_ticks(1);
        hold_until_drained();
        repeat (8) @(negedge aclk);
    endtask

    task automatic apb_access(input logic write, input logic reg_sel,
                              input logic [15:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = write;
        paddr   = {reg_sel, 2'b00};
        pwdata  = {16'h0000, value};
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_colours(input logic [15:0] fg, input logic [15:0] bg);
        apb_access(1'b1, REG_FOREGROUND, fg);
        apb_access(1'b1, REG_BACKGROUND, bg);
        apb_access(1'b0, REG_FOREGROUND, '0);
        apb_access(1'b0, REG_BACKGROUND, '0);
    endtask

    task automatic noise_request();
        draw_req_t r;
        r = random_request();
        if (r.op == OP_FILL) begin
            r = sized_fill(r);
        end else if (r.op == OP_GLYPH) begin
            if (drawable_glyphs.size() == 0)
                r.op = OP_TICK;
            else
                r.glyph = pick_glyph();
        end
        drive_request(r);
    endtask

    task automatic load_whole_glyph();
        logic [6:0] code;
        code = 7'($urandom_range(127));
        for (int row = 0; row < FONT_ROWS; row++)
            send_load(code, 3'(row), 8'($urandom));
    endtask

    // A start followed by the ticks that drain it, with loads and stray
    // requests mixed in; now and then the tick run is cut short.
    task automatic random_drawing();
        draw_req_t   r;
        int unsigned words;
        int unsigned n;
        int unsigned pick;
        r = random_request();
        if (drawable_glyphs.size() != 0 && $urandom_range(3) == 0) begin
            r.op    = OP_GLYPH;
            r.glyph = pick_glyph();
            words   = GLYPH_WORDS;
        end else begin
            r     = sized_fill(r);
            words = HEADER_WORDS + int'(r.w) * int'(r.h);
        end
        drive_request(r);
        n = words + $urandom_range(2);
        if ($urandom_range(9) == 0)
            n = $urandom_range(words);
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                r    = random_request();
                r.op = OP_LOAD;
                drive_request(r);
            end else if (pick < 6) begin
                noise_request();
            end else begin
                send_ticks(1);
            end
        end
    endtask

    initial begin
        int          stop_at;
        int unsigned pick;

        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_operation      = OP_TICK;
        s_pos_x          = '0;
        s_pos_y          = '0;
        s_rect_width     = '0;
        s_rect_height    = '0;
        s_fill_colour    = '0;
        s_glyph_code     = '0;
        s_font_row_index = '0;
        s_font_row_bits  = '0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        foreach (rows_loaded[i]) rows_loaded[i] = '0;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part, with the colours at their reset values.
        send_ticks(1);
        send_load(7'd127, 3'd0, 8'hFF);
        send_load(7'd127, 3'd1, 8'h00);
        send_load(7'd127, 3'd2, 8'h01);
        send_load(7'd127, 3'd3, 8'h80);
        send_load(7'd127, 3'd4, 8'hAA);
        send_load(7'd127, 3'd5, 8'h55);
        send_load(7'd127, 3'd6, 8'h0F);
        send_load(7'd127, 3'd7, 8'hF0);
        for (int row = 0; row < FONT_ROWS; row++)
            send_load(7'd0, 3'(row), 8'($urandom));

        // Glyph window wrapping past the top of both axes. The fill and glyph
        // starts in the middle are ignored, and the reload of the last row
        // shows up in its later pixels.
        send_glyph(16'hFFFF, 16'hFFF8, 7'd127);
        send_ticks(20);
        send_fill(16'h0010, 16'h0020, 16'd5, 16'd5, 16'h1234);
        send_glyph(16'h0000, 16'h0000, 7'd0);
        send_load(7'd127, 3'd7, 8'h3C);
        send_ticks(GLYPH_WORDS - 20);
        hold_until_drained();

        // Empty fills end on the memory-write command.
        send_fill(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_ticks(HEADER_WORDS);
        send_fill(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0000);
        send_ticks(HEADER_WORDS);
        send_fill(16'hFFFF, 16'hFFFF, 16'd2, 16'd3, 16'hA5A5);
        send_ticks(HEADER_WORDS + 6);
        send_glyph(16'h0000, 16'h0000, 7'd0);
        send_ticks(GLYPH_WORDS + 1);
        send_fill(16'h1234, 16'h5678, 16'd1, 16'd1, 16'h5A5A);
        send_ticks(HEADER_WORDS + 2);
        quiesce();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    set_colours(16'h0000, 16'hFFFF);
                end
                1: begin
                    send_idle_pct  = 45;
                    recv_stall_pct = 0;
                    set_colours(16'($urandom), 16'($urandom));
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 45;
                    set_colours(16'hFFFF, 16'h0000);
                end
                default: begin
                    send_idle_pct  = 30;
                    recv_stall_pct = 30;
                    set_colours(16'($urandom), 16'($urandom));
                end
            endcase
            stop_at = requests_sent + PHASE_ITEMS;
            while (requests_sent < stop_at) begin
                if ($urandom_range(24) == 0)
                    hold_until_drained();
                pick = $urandom_range(99);
                if (pick < 10)
                    noise_request();
                else if (pick < 18)
                    load_whole_glyph();
                else
                    random_drawing();
            end
            quiesce();
        end

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
sv/tftdc_pkg.sv
sv/tft_draw_command_sequencer.sv
test/tft_draw_checker.sv
test/tft_draw_command_sequencer_tb.sv
